@@ design/fsp_pkg.sv @@
// Shared types and constants of the fixed-step frame pacer.
package fsp_pkg;

  localparam int unsigned FREQ_BITS  = 32;
  localparam int unsigned FPS_BITS   = 10;
  localparam int unsigned DELTA_BITS = 32;
  localparam int unsigned ACC_BITS   = 43;
  localparam int unsigned SEC_BITS   = 33;
  localparam int unsigned ADDED_BITS = 42;
  localparam int unsigned OUT_BITS   = 32;
  localparam int unsigned ITER_BITS  = 6;

  localparam logic [FREQ_BITS-1:0]  FREQ_RESET = 32'd1000;
  localparam logic [FPS_BITS-1:0]   FPS_RESET  = 10'd25;
  localparam logic [DELTA_BITS-1:0] DELTA_MAX  = '1;

  // Iteration counts of the shared divider: the full accumulator, and the
  // one-second window, which sits left-aligned in the dividend.
  localparam logic [ITER_BITS-1:0] ITERS_ACC = 6'd43;
  localparam logic [ITER_BITS-1:0] ITERS_SEC = 6'd33;

  // Register indexes on the configuration port
  localparam logic REG_TICK_FREQ = 1'b0;
  localparam logic REG_FPS       = 1'b1;

  typedef struct packed {
    logic [FREQ_BITS-1:0] tick_frequency;
    logic [FPS_BITS-1:0]  frames_per_second;
  } fsp_cfg_t;

  typedef struct packed {
    logic                 start;
    logic [ITER_BITS-1:0] iters;
  } fsp_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fsp_div_sts_t;

endpackage

@@ design/fixed_step_frame_pacer.sv @@
// Top level of the fixed-step frame pacer: sequencer, timing state and output register.
//
// Input channel (in_valid_i/in_ready_o) takes one item: func_i = 0 is an update
// carrying timestamp_i, func_i = 1 is a jump that loads new_frame_i into the frame
// counter and clears all timing state. Every item yields exactly one result on the
// output channel (out_valid_o/out_ready_i): frames added, the frame counter and the
// updates measured over the last completed second.
// An update passes through accept, multiply and divider start, a run of the shared divider
// for the frame accumulator and a finish step. Crossing the one-second window adds a second
// divider run to reduce the window. A jump goes from accept straight to the finish step.
// The divider produces one quotient bit per cycle; one item is in work at a time.
// The result sits in an output register, so the next item is accepted while it
// waits; if a further result is ready before the receiver takes the last one, the
// sequencer holds in its finish step until the output register frees.
// Reset clears all timing state and the output valid flag, and sets the tick frequency
// to 1000 and the frame rate to 25. The user is to write configuration over the APB-style
// port only while the block is idle; the block itself does not enforce this.
module fixed_step_frame_pacer import fsp_pkg::*; #(
  parameter int unsigned STAMP_BITS = 48,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [STAMP_BITS-1:0] timestamp_i,
  input  logic [31:0]           new_frame_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [41:0]           frames_added_o,
  output logic [31:0]           frame_number_o,
  output logic [31:0]           updates_per_second_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIVF = 3'd3;
  localparam logic [2:0] S_DIVS = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  fsp_cfg_t             cfg;
  fsp_div_ctl_t         div_ctl;
  fsp_div_sts_t         div_sts;
  logic [ACC_BITS-1:0]  div_dividend;
  logic [ACC_BITS-1:0]  div_quo;
  logic [FREQ_BITS-1:0] div_rem;
  logic [FREQ_BITS-1:0] freq_eff;

  logic [2:0]            state_q, state_d;
  logic [STAMP_BITS-1:0] last_q, last_d;
  logic [ACC_BITS-1:0]   acc_q, acc_d;
  logic [COUNT_BITS-1:0] frame_q, frame_d;
  logic [SEC_BITS-1:0]   sec_q, sec_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] rate_q, rate_d;
  logic [DELTA_BITS-1:0] delta_q, delta_d;
  logic [ADDED_BITS-1:0] prod_q, prod_d;
  logic [ADDED_BITS-1:0] added_q, added_d;

  logic                  out_valid_q, out_valid_d;
  logic [ADDED_BITS-1:0] out_added_q;
  logic [OUT_BITS-1:0]   out_frame_q;
  logic [OUT_BITS-1:0]   out_rate_q;
  logic                  out_load;

  logic                  in_fire;
  logic [STAMP_BITS-1:0] stamp_diff;
  logic [63:0]           diff_wide;
  logic [DELTA_BITS-1:0] delta_new;
  logic                  sec_cross;
  logic                  sec_multi;

  fsp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fsp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (div_ctl),
    .dividend_i  (div_dividend),
    .divisor_i   (freq_eff),
    .sts_o       (div_sts),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign freq_eff   = (cfg.tick_frequency == '0) ? FREQ_BITS'(1) : cfg.tick_frequency;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Ticks since the previous update, saturated to the delta width, and zero while no previous timestamp is held
  assign stamp_diff = timestamp_i - last_q;
  assign diff_wide  = 64'(stamp_diff);
  always_comb begin
    if (last_q == '0) begin
      delta_new = '0;
    end else if (diff_wide > 64'(DELTA_MAX)) begin
      delta_new = DELTA_MAX;
    end else begin
      delta_new = DELTA_BITS'(diff_wide);
    end
  end

  assign sec_cross = {1'b0, sec_q} >= {2'b00, freq_eff};
  assign sec_multi = {1'b0, sec_q} >= {1'b0, freq_eff, 1'b0};

  always_comb begin
    state_d      = state_q;
    last_d       = last_q;
    acc_d        = acc_q;
    frame_d      = frame_q;
    sec_d        = sec_q;
    cnt_d        = cnt_q;
    rate_d       = rate_q;
    delta_d      = delta_q;
    prod_d       = prod_q;
    added_d      = added_q;
    div_ctl      = '0;
    div_dividend = acc_q + ACC_BITS'(prod_q);
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (func_i) begin
            frame_d = COUNT_BITS'(new_frame_i);
            last_d  = '0;
            acc_d   = '0;
            sec_d   = '0;
            cnt_d   = '0;
            rate_d  = '0;
            added_d = '0;
            state_d = S_FIN;
          end else begin
            delta_d = delta_new;
            last_d  = timestamp_i;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_d  = ADDED_BITS'(delta_q) * ADDED_BITS'(cfg.frames_per_second);
        sec_d   = sec_q + SEC_BITS'(delta_q);
        cnt_d   = cnt_q + 1'b1;
        state_d = S_ADD;
      end
      S_ADD: begin
        div_ctl.start = 1'b1;
        div_ctl.iters = ITERS_ACC;
        state_d       = S_DIVF;
      end
      S_DIVF: begin
        if (div_sts.done) begin
          added_d = div_quo[ADDED_BITS-1:0];
          frame_d = frame_q + COUNT_BITS'(div_quo);
          acc_d   = ACC_BITS'(div_rem);
          if (sec_cross) begin
            // Close the window: take the count, drop it when two seconds or more went by
            rate_d        = sec_multi ? '0 : cnt_q;
            cnt_d         = '0;
            div_dividend  = {sec_q, {(ACC_BITS - SEC_BITS){1'b0}}};
            div_ctl.start = 1'b1;
            div_ctl.iters = ITERS_SEC;
            state_d       = S_DIVS;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_DIVS: begin
        if (div_sts.done) begin
          sec_d   = SEC_BITS'(div_rem);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      acc_q       <= '0;
      frame_q     <= '0;
      sec_q       <= '0;
      cnt_q       <= '0;
      rate_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      acc_q       <= acc_d;
      frame_q     <= frame_d;
      sec_q       <= sec_d;
      cnt_q       <= cnt_d;
      rate_q      <= rate_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    prod_q  <= prod_d;
    added_q <= added_d;
    if (out_load) begin
      out_added_q <= added_q;
      out_frame_q <= OUT_BITS'(frame_q);
      out_rate_q  <= OUT_BITS'(rate_q);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign frames_added_o       = out_added_q;
  assign frame_number_o       = out_frame_q;
  assign updates_per_second_o = out_rate_q;

endmodule

@@ design/fsp_regs.sv @@
// Configuration registers of the frame pacer behind an APB-style port.
module fsp_regs import fsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output fsp_cfg_t    cfg_o
);

  logic [FREQ_BITS-1:0] freq_q, freq_d;
  logic [FPS_BITS-1:0]  fps_q, fps_d;
  logic                 wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    freq_d = freq_q;
    fps_d  = fps_q;
    if (wr_en) begin
      case (paddr[2])
        REG_TICK_FREQ: freq_d = pwdata;
        REG_FPS:       fps_d  = pwdata[FPS_BITS-1:0];
        default:       freq_d = freq_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQ_RESET;
      fps_q  <= FPS_RESET;
    end else begin
      freq_q <= freq_d;
      fps_q  <= fps_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TICK_FREQ: prdata = freq_q;
      REG_FPS:       prdata = {{(32 - FPS_BITS){1'b0}}, fps_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.tick_frequency    = freq_q;
  assign cfg_o.frames_per_second = fps_q;

endmodule

@@ design/fsp_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module fsp_div import fsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fsp_div_ctl_t         ctl_i,
  input  logic [ACC_BITS-1:0]  dividend_i,
  input  logic [FREQ_BITS-1:0] divisor_i,
  output fsp_div_sts_t         sts_o,
  output logic [ACC_BITS-1:0]  quotient_o,
  output logic [FREQ_BITS-1:0] remainder_o
);

  logic [ACC_BITS-1:0]  quo_q, quo_d;
  logic [FREQ_BITS-1:0] rem_q, rem_d;
  logic [FREQ_BITS-1:0] dvs_q, dvs_d;
  logic [ITER_BITS-1:0] cnt_q, cnt_d;
  logic [ITER_BITS-1:0] last_q, last_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [FREQ_BITS:0]   part;
  logic [FREQ_BITS:0]   trial;

  // Bring down the next dividend bit and try the subtract
  assign part  = {rem_q, quo_q[ACC_BITS-1]};
  assign trial = part - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      last_d = ctl_i.iters - 1'b1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[FREQ_BITS]) begin
        rem_d = trial[FREQ_BITS-1:0];
        quo_d = {quo_q[ACC_BITS-2:0], 1'b1};
      end else begin
        rem_d = part[FREQ_BITS-1:0];
        quo_d = {quo_q[ACC_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == last_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      last_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
